FILE: design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/aps_pkg.sv
// Types and constants of the aging priority task scheduler
`default_nettype none
package aps_pkg;

   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 20;
   localparam int STARVE_W = 5;
   localparam int LEVEL_W  = 8;
   localparam int GUARD_W  = 16;
   localparam int FREQ_W   = 17;
   localparam int SLOT_W   = 3;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [TIME_W-1:0]   USEC_PER_SEC   = 32'd1000000;
   localparam logic [STARVE_W-1:0] MAX_STARVE_RST = 5'd20;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_POLL = 2'd1,
      CMD_DONE = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      VERDICT_RUN  = 2'd0,
      VERDICT_WAIT = 2'd1,
      VERDICT_SKIP = 2'd2,
      VERDICT_ACK  = 2'd3
   } verdict_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GUARD      = 1'd0,
      REG_MAX_STARVE = 1'd1
   } reg_index_type;

   typedef struct packed {
      logic latch_req;
      logic read_i;
      logic read_c;
      logic div_start;
      logic commit;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: design/aps_divider.sv
// Restoring divider, one quotient bit per cycle
`default_nettype none
module aps_divider
   import aps_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [TIME_W-1:0]   dividend,
   input  wire logic [PERIOD_W-1:0] divisor,
   output logic                     done,
   output logic [TIME_W-1:0]        quotient,
   output logic [PERIOD_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(TIME_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TIME_W-1:0]   quo_ff, quo_in;
   logic [PERIOD_W:0]   rem_ff, rem_in;
   logic [PERIOD_W-1:0] dsr_ff, dsr_in;
   logic [PERIOD_W:0]   rem_sh;
   logic [PERIOD_W+1:0] diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      rem_sh   = {rem_ff[PERIOD_W-1:0], quo_ff[TIME_W-1]};
      diff     = {1'b0, rem_sh} - {2'b00, dsr_ff};
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         if (!diff[PERIOD_W+1]) begin
            rem_in = diff[PERIOD_W:0];
            quo_in = {quo_ff[TIME_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[TIME_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[PERIOD_W-1:0];

endmodule
`default_nettype wire

FILE: design/aps_datapath.sv
// Scheduler datapath: slot table, evaluation logic, tracking and result registers
`default_nettype none
module aps_datapath
   import aps_pkg::*;
#(
   parameter int TASKS = 8
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ctrl_cmd_type               cmd,
   output dp_status_type                   status,
   input  wire logic [1:0]                 req_cmd,
   input  wire logic [SLOT_W-1:0]          req_task_index,
   input  wire logic [TIME_W-1:0]          req_now_us,
   input  wire logic [TIME_W-1:0]          req_start_us,
   input  wire logic [FREQ_W-1:0]          req_freq_hz,
   input  wire logic signed [LEVEL_W-1:0]  req_prio_level,
   input  wire logic                       csr_we,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_W-1:0]           csr_wdata,
   output logic [1:0]                      rsp_verdict,
   output logic                            rsp_important_valid,
   output logic [SLOT_W-1:0]               rsp_important_slot,
   output logic [STARVE_W-1:0]             rsp_slot_starve,
   output logic [TIME_W-1:0]               rsp_slot_due_us
);

   localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

   // slot table
   logic [PERIOD_W-1:0] period_mem [TASKS];
   logic [LEVEL_W-1:0]  level_mem  [TASKS];
   logic [TIME_W-1:0]   due_mem    [TASKS];
   logic [TIME_W-1:0]   exec_mem   [TASKS];
   logic [STARVE_W-1:0] starve_mem [TASKS];

   // latched transaction
   cmd_type                    op_ff;
   logic [SLOT_W-1:0]          idx_ff;
   logic [TIME_W-1:0]          now_ff, start_ff;
   logic [FREQ_W-1:0]          freq_ff;
   logic [LEVEL_W-1:0]         prio_ff;

   // rows of the addressed slot and of the tracked slot
   logic [PERIOD_W-1:0] per_i_ff;
   logic [LEVEL_W-1:0]  lvl_i_ff, lvl_c_ff;
   logic [TIME_W-1:0]   due_i_ff, due_c_ff, exec_i_ff, exec_c_ff;
   logic [STARVE_W-1:0] stv_i_ff;

   logic [GUARD_W-1:0]  guard_ff;
   logic [STARVE_W-1:0] max_starve_ff;
   logic                imp_valid_ff, imp_valid_in;
   logic [IDX_W-1:0]    imp_slot_ff, imp_slot_in;

   logic [1:0]          res_verdict_ff, res_verdict_in;
   logic [STARVE_W-1:0] res_starve_ff, res_starve_in;
   logic [TIME_W-1:0]   res_due_ff, res_due_in;

   logic                in_range;
   logic [IDX_W-1:0]    slot, rd_addr;
   logic [TIME_W-1:0]   early_i, early_c, late_by, div_dividend;
   logic [PERIOD_W-1:0] div_divisor, div_rem;
   logic [TIME_W-1:0]   div_quo;
   logic                div_done;
   logic                is_rt, not_late, per_zero, poll_skip;
   logic [1:0]          poll_verdict;
   logic signed [LEVEL_W+1:0] aged, prio_i, lvl_c_ext;
   logic [STARVE_W-1:0] fed_starve;
   logic                we_load, we_starve, we_done;
   logic [TIME_W-1:0]   new_due;

   assign in_range = 7'(idx_ff) < 7'(TASKS);
   assign slot     = IDX_W'(idx_ff);
   assign rd_addr  = cmd.read_c ? imp_slot_ff : slot;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff    <= cmd_type'(req_cmd);
         idx_ff   <= req_task_index;
         now_ff   <= req_now_us;
         start_ff <= req_start_us;
         freq_ff  <= req_freq_hz;
         prio_ff  <= req_prio_level;
      end
      if (cmd.read_i) begin
         per_i_ff  <= period_mem[rd_addr];
         lvl_i_ff  <= level_mem[rd_addr];
         due_i_ff  <= due_mem[rd_addr];
         exec_i_ff <= exec_mem[rd_addr];
         stv_i_ff  <= starve_mem[rd_addr];
      end
      if (cmd.read_c) begin
         lvl_c_ff  <= level_mem[rd_addr];
         due_c_ff  <= due_mem[rd_addr];
         exec_c_ff <= exec_mem[rd_addr];
      end
   end

   // poll evaluation
   assign early_i  = due_i_ff - TIME_W'(guard_ff);
   assign early_c  = due_c_ff - TIME_W'(guard_ff);
   assign late_by  = now_ff - due_i_ff;
   assign is_rt    = (lvl_i_ff == '1);
   assign not_late = (now_ff < due_i_ff);
   assign per_zero = (per_i_ff == '0);

   always_comb begin
      poll_skip = 1'b0;
      if (now_ff < early_i) begin
         poll_skip = 1'b1;
      end else if (imp_valid_ff && imp_slot_ff != slot &&
                   early_c < now_ff + exec_i_ff) begin
         poll_skip = 1'b1;
      end
      if (poll_skip) begin
         poll_verdict = VERDICT_SKIP;
      end else if (not_late) begin
         poll_verdict = VERDICT_WAIT;
      end else begin
         poll_verdict = VERDICT_RUN;
      end
   end

   // starvation-aged priority of the addressed slot
   always_comb begin
      aged = $signed({{2{lvl_i_ff[LEVEL_W-1]}}, lvl_i_ff}) -
             $signed({{(LEVEL_W+2-STARVE_W){1'b0}}, stv_i_ff});
      if (is_rt) begin
         prio_i = '1;
      end else if (aged < 0) begin
         prio_i = '0;
      end else begin
         prio_i = aged;
      end
      lvl_c_ext = $signed({{2{lvl_c_ff[LEVEL_W-1]}}, lvl_c_ff});
   end

   // divider operands
   always_comb begin
      if (op_ff == CMD_LOAD) begin
         div_dividend = USEC_PER_SEC;
         div_divisor  = (freq_ff == '0) ? PERIOD_W'(1) : PERIOD_W'(freq_ff);
      end else begin
         div_dividend = late_by;
         div_divisor  = per_i_ff;
      end
   end

   always_comb begin
      status.div_done = div_done;
      status.need_div = 1'b0;
      if (in_range) begin
         case (op_ff)
            CMD_LOAD: status.need_div = 1'b1;
            CMD_POLL: status.need_div = poll_skip && !is_rt && !not_late && !per_zero;
            CMD_DONE: status.need_div = !not_late && !per_zero;
            default:  status.need_div = 1'b0;
         endcase
      end
   end

   aps_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      if (not_late) begin
         fed_starve = '0;
      end else if (per_zero) begin
         fed_starve = max_starve_ff;
      end else if (div_quo > TIME_W'(max_starve_ff)) begin
         fed_starve = max_starve_ff;
      end else begin
         fed_starve = div_quo[STARVE_W-1:0];
      end
      // due + period * (q + 1) reduces to now - remainder + period
      if (per_zero) begin
         new_due = due_i_ff;
      end else if (not_late) begin
         new_due = due_i_ff + TIME_W'(per_i_ff);
      end else begin
         new_due = now_ff - TIME_W'(div_rem) + TIME_W'(per_i_ff);
      end
   end

   // commit step
   always_comb begin
      we_load        = 1'b0;
      we_starve      = 1'b0;
      we_done        = 1'b0;
      imp_valid_in   = imp_valid_ff;
      imp_slot_in    = imp_slot_ff;
      res_verdict_in = VERDICT_ACK;
      res_starve_in  = '0;
      res_due_in     = '0;
      if (in_range) begin
         res_starve_in = stv_i_ff;
         res_due_in    = due_i_ff;
         case (op_ff)
            CMD_LOAD: begin
               we_load       = 1'b1;
               res_starve_in = '0;
            end
            CMD_POLL: begin
               res_verdict_in = poll_verdict;
               if (poll_skip) begin
                  if (!imp_valid_ff) begin
                     imp_valid_in = 1'b1;
                     imp_slot_in  = slot;
                  end else if (due_c_ff < due_i_ff) begin
                     if (lvl_c_ext > prio_i && exec_c_ff + due_c_ff > due_i_ff) begin
                        imp_slot_in = slot;
                     end
                  end else if (lvl_c_ext > prio_i) begin
                     imp_slot_in = slot;
                  end
                  if (!is_rt) begin
                     we_starve     = 1'b1;
                     res_starve_in = fed_starve;
                  end
               end
            end
            CMD_DONE: begin
               we_done    = 1'b1;
               res_due_in = new_due;
               if (imp_valid_ff && imp_slot_ff == slot) begin
                  imp_valid_in = 1'b0;
                  imp_slot_in  = '0;
               end
            end
            default: res_verdict_in = VERDICT_ACK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TASKS; k++) begin
            period_mem[k] <= '0;
            level_mem[k]  <= '0;
            due_mem[k]    <= '0;
            exec_mem[k]   <= '0;
            starve_mem[k] <= '0;
         end
      end else if (cmd.commit) begin
         if (we_load) begin
            period_mem[slot] <= div_quo[PERIOD_W-1:0];
            level_mem[slot]  <= prio_ff;
            starve_mem[slot] <= '0;
         end
         if (we_starve) begin
            starve_mem[slot] <= fed_starve;
         end
         if (we_done) begin
            due_mem[slot]  <= new_due;
            exec_mem[slot] <= now_ff - start_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         guard_ff      <= '0;
         max_starve_ff <= MAX_STARVE_RST;
         imp_valid_ff  <= 1'b0;
         imp_slot_ff   <= '0;
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_GUARD:      guard_ff      <= csr_wdata;
               REG_MAX_STARVE: max_starve_ff <= csr_wdata[STARVE_W-1:0];
               default:        guard_ff      <= guard_ff;
            endcase
         end
         if (cmd.commit) begin
            imp_valid_ff <= imp_valid_in;
            imp_slot_ff  <= imp_slot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_verdict_ff <= res_verdict_in;
         res_starve_ff  <= res_starve_in;
         res_due_ff     <= res_due_in;
      end
      if (cmd.load_rsp) begin
         rsp_verdict         <= res_verdict_ff;
         rsp_important_valid <= imp_valid_ff;
         rsp_important_slot  <= SLOT_W'(imp_slot_ff);
         rsp_slot_starve     <= res_starve_ff;
         rsp_slot_due_us     <= res_due_ff;
      end
   end

endmodule
`default_nettype wire

FILE: design/aps_controller.sv
// Scheduler sequencer: read, evaluate, divide if needed, commit and output steps
`default_nettype none
module aps_controller
   import aps_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_I,
      ST_READ_C,
      ST_EVAL,
      ST_DIVIDE,
      ST_COMMIT,
      ST_OUTPUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.latch_req = (state_ff == ST_IDLE) && req_valid;
      cmd.read_i    = (state_ff == ST_READ_I);
      cmd.read_c    = (state_ff == ST_READ_C);
      cmd.div_start = (state_ff == ST_EVAL) && status.need_div;
      cmd.commit    = (state_ff == ST_COMMIT);
      cmd.load_rsp  = (state_ff == ST_OUTPUT) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new response may replace one taken at the same edge
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE:   if (req_valid) state_ff <= ST_READ_I;
            ST_READ_I: state_ff <= ST_READ_C;
            ST_READ_C: state_ff <= ST_EVAL;
            ST_EVAL:   state_ff <= status.need_div ? ST_DIVIDE : ST_COMMIT;
            ST_DIVIDE: if (status.div_done) state_ff <= ST_COMMIT;
            ST_COMMIT: state_ff <= ST_OUTPUT;
            ST_OUTPUT: if (cmd.load_rsp) state_ff <= ST_IDLE;
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: design/aging_priority_task_scheduler.sv
// Aging priority task scheduler: top level joining sequencer and datapath
// Each transaction steps through read, evaluate, commit and output, with a division
// before commit for an in-range load, late skip or late completion; one at a time.
// The next request waits until the response loads; the 32-step divider is shared.
// Reset (synchronous): slot table cleared, tracking cleared, guard_us 0, max_starve 20.
`default_nettype none
module aging_priority_task_scheduler
   import aps_pkg::*;
#(
   parameter int TASKS = 8
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_cmd,
   input  wire logic [SLOT_W-1:0]          req_task_index,
   input  wire logic [TIME_W-1:0]          req_now_us,
   input  wire logic [TIME_W-1:0]          req_start_us,
   input  wire logic [FREQ_W-1:0]          req_freq_hz,
   input  wire logic signed [LEVEL_W-1:0]  req_prio_level,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [1:0]                      rsp_verdict,
   output logic                            rsp_important_valid,
   output logic [SLOT_W-1:0]               rsp_important_slot,
   output logic [STARVE_W-1:0]             rsp_slot_starve,
   output logic [TIME_W-1:0]               rsp_slot_due_us,
   input  wire logic                       csr_we,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_W-1:0]           csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   aps_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   aps_datapath #(
      .TASKS (TASKS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_cmd             (req_cmd),
      .req_task_index      (req_task_index),
      .req_now_us          (req_now_us),
      .req_start_us        (req_start_us),
      .req_freq_hz         (req_freq_hz),
      .req_prio_level      (req_prio_level),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_verdict         (rsp_verdict),
      .rsp_important_valid (rsp_important_valid),
      .rsp_important_slot  (rsp_important_slot),
      .rsp_slot_starve     (rsp_slot_starve),
      .rsp_slot_due_us     (rsp_slot_due_us)
   );

endmodule
`default_nettype wire

FILE: design/aps_checker.sv
// Port-level checks for the aging priority task scheduler, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module aps_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_verdict,
   input wire logic        rsp_important_valid,
   input wire logic [2:0]  rsp_important_slot
);

   // a stalled response holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict), "response dropped or changed while stalled")

   // one transaction at a time
   `ASSERT_CLK(a_one_in_flight, clock, reset, req_valid && req_ready |=> !req_ready, "new transaction taken while one is in flight")

   // with no tracked task the reported slot is 0
   `ASSERT_CLK(a_slot_clear, clock, reset, rsp_valid && !rsp_important_valid |-> rsp_important_slot == 3'd0, "slot reported with no tracked task")

   // reset leaves the block idle with no response pending
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready, "not idle after reset")

endmodule

bind aging_priority_task_scheduler aps_checker u_aps_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_verdict         (rsp_verdict),
   .rsp_important_valid (rsp_important_valid),
   .rsp_important_slot  (rsp_important_slot)
);
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the aging priority task scheduler
`default_nettype none
module tb;
   import aps_pkg::*;

   localparam int NSLOT = 8;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [SLOT_W-1:0]        slot;
      logic [TIME_W-1:0]        now_us;
      logic [TIME_W-1:0]        start_us;
      logic [FREQ_W-1:0]        freq_hz;
      logic signed [LEVEL_W-1:0] prio;
   } sched_req_t;

   typedef struct packed {
      logic [1:0]          verdict;
      logic                imp_valid;
      logic [SLOT_W-1:0]   imp_slot;
      logic [STARVE_W-1:0] starve;
      logic [TIME_W-1:0]   due_us;
   } sched_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_cmd = '0;
   logic [SLOT_W-1:0] req_task_index = '0;
   logic [TIME_W-1:0] req_now_us = '0;
   logic [TIME_W-1:0] req_start_us = '0;
   logic [FREQ_W-1:0] req_freq_hz = '0;
   logic signed [LEVEL_W-1:0] req_prio_level = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_verdict;
   logic rsp_important_valid;
   logic [SLOT_W-1:0] rsp_important_slot;
   logic [STARVE_W-1:0] rsp_slot_starve;
   logic [TIME_W-1:0] rsp_slot_due_us;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   aging_priority_task_scheduler DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // scheduler shadow state
   logic [PERIOD_W-1:0]       sh_period [NSLOT];
   logic signed [LEVEL_W-1:0] sh_level [NSLOT];
   logic [TIME_W-1:0]         sh_due [NSLOT];
   logic [TIME_W-1:0]         sh_exec [NSLOT];
   logic [STARVE_W-1:0]       sh_starve [NSLOT];
   logic                      sh_imp_valid;
   logic [SLOT_W-1:0]         sh_imp_slot;
   logic [GUARD_W-1:0]        sh_guard;
   logic [STARVE_W-1:0]       sh_max_starve;

   sched_req_t pending_reqs[$];
   sched_rsp_t expected_rsps[$];
   int idle_pct = 0;
   int stall_pct = 0;
   int errors = 0;
   int quiet_cycles = 0;

   function automatic void update_important(int i);
      int c;
      int aged;
      if (!sh_imp_valid) begin
         sh_imp_valid = 1'b1;
         sh_imp_slot = SLOT_W'(i);
         return;
      end
      c = sh_imp_slot;
      if (sh_level[i] != -1) begin
         aged = int'(sh_level[i]) - int'(sh_starve[i]);
         if (aged < 0) aged = 0;
      end else begin
         aged = -1;
      end
      if (sh_due[c] < sh_due[i]) begin
         if (int'(sh_level[c]) > aged &&
             32'(sh_exec[c] + sh_due[c]) > sh_due[i]) sh_imp_slot = SLOT_W'(i);
      end else if (int'(sh_level[c]) > aged) begin
         sh_imp_slot = SLOT_W'(i);
      end
   endfunction

   function automatic sched_rsp_t schedule_step(sched_req_t r);
      sched_rsp_t o;
      int i;
      logic [TIME_W-1:0] early;
      logic [TIME_W-1:0] q;
      logic [63:0] mult;
      logic [FREQ_W-1:0] f;
      i = r.slot;
      o.verdict = VERDICT_ACK;
      case (r.cmd)
         CMD_LOAD: begin
            f = (r.freq_hz == 0) ? FREQ_W'(1) : r.freq_hz;
            sh_period[i] = PERIOD_W'(USEC_PER_SEC / f);
            sh_level[i] = r.prio;
            sh_starve[i] = '0;
         end
         CMD_POLL: begin
            early = sh_due[i] - sh_guard;
            if (r.now_us < early) o.verdict = VERDICT_SKIP;
            else if (sh_imp_valid && sh_imp_slot != i &&
                     32'(sh_due[sh_imp_slot] - sh_guard) < 32'(r.now_us + sh_exec[i]))
               o.verdict = VERDICT_SKIP;
            else if (r.now_us < sh_due[i]) o.verdict = VERDICT_WAIT;
            else o.verdict = VERDICT_RUN;
            if (o.verdict == VERDICT_SKIP) begin
               update_important(i);
               if (sh_level[i] != -1) begin
                  if (r.now_us < sh_due[i]) sh_starve[i] = '0;
                  else begin
                     if (sh_period[i] == 0) q = sh_max_starve;
                     else q = (r.now_us - sh_due[i]) / sh_period[i];
                     sh_starve[i] = (q > sh_max_starve) ? sh_max_starve : q[STARVE_W-1:0];
                  end
               end
            end
         end
         CMD_DONE: begin
            if (sh_period[i] != 0) begin
               if (r.now_us < sh_due[i]) mult = 1;
               else mult = 64'((r.now_us - sh_due[i]) / sh_period[i]) + 1;
               sh_due[i] = 32'(64'(sh_due[i]) + 64'(sh_period[i]) * mult);
            end
            sh_exec[i] = r.now_us - r.start_us;
            if (sh_imp_valid && sh_imp_slot == i) begin
               sh_imp_valid = 1'b0;
               sh_imp_slot = '0;
            end
         end
         default: ;
      endcase
      o.imp_valid = sh_imp_valid;
      o.imp_slot = sh_imp_valid ? sh_imp_slot : '0;
      o.starve = sh_starve[i];
      o.due_us = sh_due[i];
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid && req_ready) expected_rsps.push_back(schedule_step({req_cmd,
            req_task_index, req_now_us, req_start_us, req_freq_hz, req_prio_level}));
         if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
            sched_req_t r;
            r = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_cmd <= r.cmd;
            req_task_index <= r.slot;
            req_now_us <= r.now_us;
            req_start_us <= r.start_us;
            req_freq_hz <= r.freq_hz;
            req_prio_level <= r.prio;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response with nothing expected");
               errors++;
            end else begin
               sched_rsp_t e;
               e = expected_rsps.pop_front();
               if (rsp_verdict !== e.verdict) begin
                  $error("verdict exp %0d got %0d", e.verdict, rsp_verdict); errors++;
               end
               if (rsp_important_valid !== e.imp_valid) begin
                  $error("important_valid exp %0d got %0d", e.imp_valid,
                         rsp_important_valid); errors++;
               end
               if (rsp_important_slot !== e.imp_slot) begin
                  $error("important_slot exp %0d got %0d", e.imp_slot,
                         rsp_important_slot); errors++;
               end
               if (rsp_slot_starve !== e.starve) begin
                  $error("slot_starve exp %0d got %0d", e.starve, rsp_slot_starve);
                  errors++;
               end
               if (rsp_slot_due_us !== e.due_us) begin
                  $error("slot_due_us exp %0h got %0h", e.due_us, rsp_slot_due_us);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset ||
          (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_valid))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("aging_priority_task_scheduler verification failed");
         $finish;
      end
   end

   function automatic sched_req_t make_req(logic [1:0] cmd, int slot, logic [31:0] now_us,
                                           logic [31:0] start_us, logic [16:0] freq,
                                           logic [7:0] prio);
      sched_req_t r;
      r.cmd = cmd; r.slot = SLOT_W'(slot); r.now_us = now_us; r.start_us = start_us;
      r.freq_hz = freq; r.prio = prio;
      return r;
   endfunction

   // mostly well-formed: times near each slot's due time
   function automatic sched_req_t random_req();
      int s;
      int k;
      logic [31:0] base;
      s = $urandom_range(NSLOT - 1);
      k = $urandom_range(99);
      base = sh_due[s] + 32'($urandom_range(4000)) - 32'd1500;
      if (k < 12)
         return make_req(CMD_LOAD, s, $urandom, $urandom,
                         ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(1, 5000)),
                         ($urandom_range(3) == 0) ? 8'hff : 8'($urandom_range(0, 127)));
      else if (k < 60)
         return make_req(CMD_POLL, s, ($urandom_range(15) == 0) ? $urandom :
                         base + 32'($urandom_range(40000)), $urandom, $urandom, $urandom);
      else if (k < 95)
         return make_req(CMD_DONE, s, ($urandom_range(15) == 0) ? $urandom : base +
                         32'($urandom_range(20000)), base - 32'($urandom_range(3000)),
                         $urandom, $urandom);
      else
         return make_req(($urandom_range(1) == 0) ? CMD_NONE : 2'($urandom_range(2)), s,
                         $urandom, $urandom, $urandom, $urandom);
   endfunction

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [CSR_W-1:0] v);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_GUARD) sh_guard = v;
      else sh_max_starve = v[STARVE_W-1:0];
      @(posedge clock);
   endtask

   task automatic random_phase(int n, int idle, int stall);
      idle_pct = idle;
      stall_pct = stall;
      for (int j = 0; j < n; j++) begin
         // predictor state advances only as the driver accepts, so feed in small batches
         while (pending_reqs.size() > 2) @(posedge clock);
         pending_reqs.push_back(random_req());
      end
      drain();
   endtask

   initial begin
      for (int s = 0; s < NSLOT; s++) begin
         sh_period[s] = '0; sh_level[s] = '0; sh_due[s] = '0;
         sh_exec[s] = '0; sh_starve[s] = '0;
      end
      sh_imp_valid = 1'b0; sh_imp_slot = '0;
      sh_guard = '0; sh_max_starve = MAX_STARVE_RST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: never-loaded slot, extremes, every command
      pending_reqs.push_back(make_req(CMD_POLL, 0, 32'd0, 0, 0, 0));
      pending_reqs.push_back(make_req(CMD_POLL, 1, 32'hffff_ffff, 0, 0, 0));
      pending_reqs.push_back(make_req(CMD_DONE, 1, 32'd500, 32'hffff_ffff, 0, 0));
      pending_reqs.push_back(make_req(CMD_LOAD, 2, 0, 0, 17'd0, 8'sd127));
      pending_reqs.push_back(make_req(CMD_LOAD, 3, 0, 0, 17'h1ffff, -8'sd1));
      pending_reqs.push_back(make_req(CMD_LOAD, 4, 0, 0, 17'd100000, -8'sd128));
      pending_reqs.push_back(make_req(CMD_LOAD, 5, 0, 0, 17'd1000, 8'sd5));
      pending_reqs.push_back(make_req(CMD_DONE, 5, 32'd0, 0, 0, 0));
      pending_reqs.push_back(make_req(CMD_DONE, 5, 32'd100000, 32'd99000, 0, 0));
      pending_reqs.push_back(make_req(CMD_POLL, 5, 32'd10, 0, 0, 0));
      pending_reqs.push_back(make_req(CMD_POLL, 5, 32'hffff_fff0, 0, 0, 0));
      pending_reqs.push_back(make_req(CMD_POLL, 2, 32'hffff_ffff, 0, 0, 0));
      pending_reqs.push_back(make_req(CMD_POLL, 3, 32'd5, 0, 0, 0));
      pending_reqs.push_back(make_req(CMD_DONE, 2, 32'hffff_ffff, 32'd0, 0, 0));
      pending_reqs.push_back(make_req(CMD_NONE, 7, '1, '1, '1, '1));
      pending_reqs.push_back(make_req(CMD_DONE, 7, 32'h8000_0000, 32'h7fff_ffff, 0, 0));
      // the sender holds off here until every response is back
      drain();

      random_phase(160, 0, 0);
      csr_write(REG_GUARD, 16'hffff);
      csr_write(REG_MAX_STARVE, 5'd0);
      random_phase(160, 82, 0);
      csr_write(REG_GUARD, 16'd300);
      csr_write(REG_MAX_STARVE, 5'd31);
      random_phase(160, 0, 82);
      csr_write(REG_GUARD, 16'd0);
      csr_write(REG_MAX_STARVE, 5'd3);
      random_phase(160, 38, 38);

      if (errors == 0)
         $display("aging_priority_task_scheduler verification clean");
      else
         $display("aging_priority_task_scheduler verification failed");
      $finish;
   end
endmodule
`default_nettype wire

FILE: aging_priority_task_scheduler.f
+incdir+design
design/aps_pkg.sv
design/aps_divider.sv
design/aps_datapath.sv
design/aps_controller.sv
design/aging_priority_task_scheduler.sv
design/aps_checker.sv
tb/tb.sv
